FILE: src/prqr_pkg.sv
// ----------------------------------------------------------------------------
// prqr_pkg
// Shared types and constants for the priority rotation queue rank block.
// ----------------------------------------------------------------------------
package prqr_pkg;

  localparam int QUEUE_DEPTH   = 64;
  localparam int PRIORITY_BITS = 8;

  localparam int ADDR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int PRI_W    = PRIORITY_BITS;
  localparam int REQ_W    = 8;
  localparam int TGT_W    = 6;
  localparam int RANK_W   = 7;
  localparam int ERR_W    = 2;
  localparam int CMP_W    = (CNT_W > TGT_W) ? CNT_W : TGT_W;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - RANK_W - ERR_W;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK       = 2'd0,
    ERR_TARGET   = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_code_t;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_CHECK     = 7'b0000010,
    ST_SCAN_INIT = 7'b0000100,
    ST_SCAN      = 7'b0001000,
    ST_POP_RD    = 7'b0010000,
    ST_POP_EVAL  = 7'b0100000,
    ST_FINISH    = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] origin;
    logic [PRI_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic push;       // a job request is accepted this cycle
    logic set_err;    // latch an error result
    logic scan_start; // restart the maximum scan at the head
    logic scan_run;   // step the maximum scan
    logic pop_eval;   // front entry read data is valid, rotate or execute
    logic finish;     // move the result to the output register and clear
  } prqr_cmd_t;

  typedef struct packed {
    logic overflow;
    logic target_bad;
    logic scan_done;
    logic rotate;
    logic hit;
    logic out_free;
  } prqr_status_t;

endpackage

FILE: src/prqr_ctrl.sv
// ----------------------------------------------------------------------------
// prqr_ctrl
// Sequencer for loading, checking and running the rotation queue.
// ----------------------------------------------------------------------------
module prqr_ctrl import prqr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         in_last,
  output logic         in_ready,
  input  prqr_status_t status,
  output prqr_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.push = 1'b1;
          if (in_last) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (status.overflow || status.target_bad) begin
          cmd.set_err = 1'b1;
          state_next  = ST_FINISH;
        end else begin
          state_next = ST_SCAN_INIT;
        end
      end
      ST_SCAN_INIT: begin
        cmd.scan_start = 1'b1;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.scan_done) begin
          state_next = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        state_next = ST_POP_EVAL;
      end
      ST_POP_EVAL: begin
        cmd.pop_eval = 1'b1;
        if (status.rotate) begin
          state_next = ST_POP_RD;
        end else if (status.hit) begin
          state_next = ST_FINISH;
        end else begin
          // The maximum can only drop after an entry executes.
          state_next = ST_SCAN_INIT;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/prqr_datapath.sv
// ----------------------------------------------------------------------------
// prqr_datapath
// Ring memory, queue pointers, maximum scan and the result register.
// ----------------------------------------------------------------------------
module prqr_datapath import prqr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  prqr_cmd_t         cmd,
  input  logic [REQ_W-1:0]  prio_in,
  input  logic [TGT_W-1:0]  target_in,
  output prqr_status_t      status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RANK_W-1:0] out_rank,
  output logic [ERR_W-1:0]  out_err
);

  entry_t ring [QUEUE_DEPTH];
  entry_t rd_data;

  logic [ADDR_W-1:0] head_ptr;
  logic [CNT_W-1:0]  entry_count;
  logic [RANK_W-1:0] run_count;
  logic              overflow_seen;
  logic [TGT_W-1:0]  target_q;
  logic [PRI_W-1:0]  best;
  logic [ADDR_W-1:0] scan_ptr;
  logic [CNT_W-1:0]  scan_cnt;
  logic              scan_pend;
  logic [RANK_W-1:0] res_rank;
  err_code_t         res_err;

  logic [PRI_W-1:0]  pri_in;
  logic              full;
  logic [ADDR_W-1:0] head_inc;
  logic [ADDR_W-1:0] scan_inc;
  logic [CNT_W:0]    tail_sum;
  logic [CNT_W:0]    tail_wrap;
  logic [ADDR_W-1:0] tail_ptr;
  logic              scan_issue;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;
  logic              rotate;
  logic              hit;

  always_comb begin
    pri_in    = PRI_W'(prio_in);
    full      = (entry_count == CNT_W'(QUEUE_DEPTH));
    head_inc  = (head_ptr == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ptr + 1'b1;
    scan_inc  = (scan_ptr == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : scan_ptr + 1'b1;
    // After the front is taken off, the tail slot sits entry_count past the old head.
    tail_sum  = (CNT_W+1)'(head_ptr) + (CNT_W+1)'(entry_count);
    tail_wrap = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                tail_sum - (CNT_W+1)'(QUEUE_DEPTH) : tail_sum;
    tail_ptr  = tail_wrap[ADDR_W-1:0];

    scan_issue = cmd.scan_run && (scan_cnt != entry_count);
    rd_addr    = scan_issue ? scan_ptr : head_ptr;

    rotate = rd_data.prio < best;
    hit    = CMP_W'(rd_data.origin) == CMP_W'(target_q);

    wr_en   = 1'b0;
    wr_addr = entry_count[ADDR_W-1:0];
    wr_data = '{origin: entry_count[ADDR_W-1:0], prio: pri_in};
    if (cmd.push && !full) begin
      wr_en = 1'b1;
    end else if (cmd.pop_eval && rotate) begin
      wr_en   = 1'b1;
      wr_addr = tail_ptr;
      wr_data = rd_data;
    end

    status.overflow   = overflow_seen;
    status.target_bad = CMP_W'(target_q) >= CMP_W'(entry_count);
    status.scan_done  = (scan_cnt == entry_count) && !scan_pend;
    status.rotate     = rotate;
    status.hit        = hit;
    status.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= wr_data;
    end
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr      <= '0;
      entry_count   <= '0;
      run_count     <= '0;
      overflow_seen <= 1'b0;
      scan_cnt      <= '0;
      scan_pend     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      scan_pend <= scan_issue;
      if (cmd.push) begin
        if (full) begin
          overflow_seen <= 1'b1;
        end else begin
          entry_count <= entry_count + 1'b1;
        end
      end
      if (cmd.scan_start) begin
        scan_cnt <= '0;
      end else if (scan_issue) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (cmd.pop_eval) begin
        head_ptr <= head_inc;
        if (!rotate) begin
          entry_count <= entry_count - 1'b1;
          run_count   <= run_count + 1'b1;
        end
      end
      if (cmd.finish) begin
        head_ptr      <= '0;
        entry_count   <= '0;
        run_count     <= '0;
        overflow_seen <= 1'b0;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      target_q <= target_in;
    end
    if (cmd.scan_start) begin
      best     <= '0;
      scan_ptr <= head_ptr;
    end else begin
      if (scan_issue) begin
        scan_ptr <= scan_inc;
      end
      if (scan_pend && (rd_data.prio > best)) begin
        best <= rd_data.prio;
      end
    end
    if (cmd.set_err) begin
      res_rank <= '0;
      res_err  <= overflow_seen ? ERR_OVERFLOW : ERR_TARGET;
    end else if (cmd.pop_eval && !rotate && hit) begin
      res_rank <= run_count + 1'b1;
      res_err  <= ERR_OK;
    end
    if (cmd.finish) begin
      out_rank <= res_rank;
      out_err  <= res_err;
    end
  end

endmodule

FILE: src/priority_rotation_queue_rank.sv
// ----------------------------------------------------------------------------
// priority_rotation_queue_rank
// Loads a list of job priorities into a circular queue and, on the last job,
// runs the queue to find the 1-based execution rank of the target job.
//
//   Channel   Dir  Contents
//   s_axis    in   tdata[7:0] priority_req, tdata[13:8] target_index, tlast last
//   m_axis    out  tdata[6:0] exec_rank, tdata[8:7] error_code
//
// Job requests that are not last are taken back to back while idle. A last
// request starts a run: for N queued jobs, every execution costs a maximum
// scan of the ring memory, and every rotation or pop costs a registered
// memory read.
// Reset is synchronous; the ring memory is not cleared and needs no pass.
// While a result waits in the output register, new requests are still taken.
// ----------------------------------------------------------------------------
module priority_rotation_queue_rank import prqr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // priority_req, target_index
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // exec_rank, error_code
);

  prqr_cmd_t         cmd;
  prqr_status_t      status;
  logic [RANK_W-1:0] exec_rank;
  logic [ERR_W-1:0]  error_code;

  prqr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  prqr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .prio_in   (s_axis_tdata[REQ_W-1:0]),
    .target_in (s_axis_tdata[REQ_W +: TGT_W]),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rank  (exec_rank),
    .out_err   (error_code)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, error_code, exec_rank};

endmodule
